FILE: hdl/erx_pkg.sv
// Shared types and constants for the ZYX Euler rigid transform.
// No dependencies; used by the sine, matrix, lane and top-level files and the testbench.
`default_nettype none

package erx_pkg;

  // Register indexes of the configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_YAW     = 3'd5;

  // Odd polynomial for sine over a quarter turn, Q30
  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598668;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C7 = 31'd5026995;
  localparam logic [30:0] SIN_C9 = 31'd172272;

  // Matrix program: operand sources, destinations and accumulate modes
  typedef enum logic [2:0] {
    SRC_CA, SRC_SA, SRC_CP, SRC_SP, SRC_CY, SRC_SY, SRC_TMP
  } src_t;

  typedef enum logic [3:0] {
    DST_M00, DST_M01, DST_M02, DST_M10, DST_M11, DST_M12,
    DST_M20, DST_M21, DST_M22, DST_TMP
  } dst_t;

  typedef enum logic [1:0] {
    ACC_SET, ACC_ADD, ACC_SUB
  } acc_t;

  typedef struct packed {
    src_t src_a;
    src_t src_b;
    dst_t dst;
    acc_t mode;
  } mat_op_t;

  localparam int NUM_OPS = 16;

  function automatic mat_op_t mat_op(input logic [3:0] idx);
    mat_op_t op;
    op = '{SRC_CY, SRC_CP, DST_M00, ACC_SET};
    unique case (idx)
      4'd0:  op = '{SRC_CY,  SRC_CP, DST_M00, ACC_SET};
      4'd1:  op = '{SRC_CY,  SRC_SA, DST_TMP, ACC_SET};
      4'd2:  op = '{SRC_TMP, SRC_SP, DST_M01, ACC_SET};
      4'd3:  op = '{SRC_CA,  SRC_SY, DST_M01, ACC_SUB};
      4'd4:  op = '{SRC_SA,  SRC_SY, DST_M02, ACC_SET};
      4'd5:  op = '{SRC_CA,  SRC_CY, DST_TMP, ACC_SET};
      4'd6:  op = '{SRC_TMP, SRC_SP, DST_M02, ACC_ADD};
      4'd7:  op = '{SRC_CP,  SRC_SY, DST_M10, ACC_SET};
      4'd8:  op = '{SRC_CA,  SRC_CY, DST_M11, ACC_SET};
      4'd9:  op = '{SRC_SA,  SRC_SY, DST_TMP, ACC_SET};
      4'd10: op = '{SRC_TMP, SRC_SP, DST_M11, ACC_ADD};
      4'd11: op = '{SRC_CA,  SRC_SY, DST_TMP, ACC_SET};
      4'd12: op = '{SRC_TMP, SRC_SP, DST_M12, ACC_SET};
      4'd13: op = '{SRC_CY,  SRC_SA, DST_M12, ACC_SUB};
      4'd14: op = '{SRC_CP,  SRC_SA, DST_M21, ACC_SET};
      4'd15: op = '{SRC_CA,  SRC_CP, DST_M22, ACC_SET};
      default: op = '{SRC_CY, SRC_CP, DST_M00, ACC_SET};
    endcase
    return op;
  endfunction

  // Per-lane control for one pipeline step
  typedef struct packed {
    logic en;
    logic bypass;
  } lane_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/erx_point_if.sv
// Valid/ready channel carrying one 3D point word.
// Depends on nothing; used by the top level for the input channel.
`default_nettype none

interface erx_point_if #(parameter int W = 24);
  logic         valid;
  logic         ready;
  logic [W-1:0] point_x;
  logic [W-1:0] point_y;
  logic [W-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

`default_nettype wire

FILE: hdl/erx_moved_if.sv
// Valid/ready channel carrying one transformed point word and its clip flag.
// Depends on nothing; used by the top level.
`default_nettype none

interface erx_moved_if #(parameter int W = 24);
  logic         valid;
  logic         ready;
  logic [W-1:0] moved_x;
  logic [W-1:0] moved_y;
  logic [W-1:0] moved_z;
  logic         clipped;

  modport source (output valid, moved_x, moved_y, moved_z, clipped, input ready);
  modport sink   (input valid, moved_x, moved_y, moved_z, clipped, output ready);
endinterface

`default_nettype wire

FILE: hdl/erx_sin.sv
// Iterative sine: quadrant fold plus a Q30 odd polynomial, one multiply a cycle.
// Depends on erx_pkg for the polynomial constants.
`default_nettype none

module erx_sin
  import erx_pkg::*;
#(
  parameter int ANGLE_WIDTH = 16,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ANGLE_WIDTH-1:0]       angle,
  output logic                         done,
  output logic signed [COEF_WIDTH-1:0] value
);

  localparam int F     = COEF_WIDTH - 1;
  localparam int FB    = ANGLE_WIDTH - 2;
  localparam int XSH   = 30 - FB;
  localparam int RSH   = 30 - F;
  localparam logic [32:0] HALF = 33'd1 << (RSH - 1);
  localparam logic [32:0] SMAX = (33'd1 << F) - 33'd1;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t      state_r;
  logic [2:0]  cnt_r;
  logic [1:0]  q_r;
  logic [30:0] x_r;
  logic [30:0] x2_r;
  logic [30:0] p_r;
  logic        done_r;
  logic signed [COEF_WIDTH-1:0] value_r;

  logic [30:0] x_raw;
  logic [30:0] ma, mb;
  logic [61:0] prod;
  logic [30:0] cnext;
  logic [32:0] s_rnd;
  logic [32:0] s_sh;
  logic [COEF_WIDTH-1:0] s_mag;

  // Fraction within the quadrant before the fold, Q30
  assign x_raw = 31'(angle[FB-1:0]) << XSH;

  // Shared multiplier operands
  always_comb begin
    ma = ((cnt_r == 3'd0) || (cnt_r == 3'd5)) ? x_r : x2_r;
    mb = (cnt_r == 3'd0) ? x_r : p_r;
    prod = ma * mb;
    unique case (cnt_r)
      3'd1:    cnext = SIN_C7;
      3'd2:    cnext = SIN_C5;
      3'd3:    cnext = SIN_C3;
      default: cnext = SIN_C1;
    endcase
  end

  // Final rounding to F fraction bits with saturation
  always_comb begin
    s_rnd = {1'b0, prod[61:30]} + HALF;
    s_sh  = s_rnd >> RSH;
    s_mag = (s_sh > SMAX) ? COEF_WIDTH'(SMAX) : s_sh[COEF_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 3'd0;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == S_RUN) && (cnt_r == 3'd5);
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            q_r     <= angle[ANGLE_WIDTH-1:ANGLE_WIDTH-2];
            x_r     <= angle[ANGLE_WIDTH-2] ? ((31'd1 << 30) - x_raw) : x_raw;
            p_r     <= SIN_C9;
            cnt_r   <= 3'd0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (cnt_r == 3'd0) begin
            x2_r <= prod[60:30];
          end else if (cnt_r == 3'd5) begin
            value_r <= q_r[1] ? -$signed(s_mag) : $signed(s_mag);
            state_r <= S_IDLE;
          end else begin
            p_r <= cnext - prod[60:30];
          end
          cnt_r <= cnt_r + 3'd1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign value = value_r;

endmodule

`default_nettype wire

FILE: hdl/erx_coef.sv
// Rotation matrix builder: six sines/cosines, then a 16-step fixed program.
// Depends on erx_pkg (program table) and erx_sin.
`default_nettype none

module erx_coef
  import erx_pkg::*;
#(
  parameter int ANGLE_WIDTH = 16,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [ANGLE_WIDTH-1:0]         roll,
  input  logic [ANGLE_WIDTH-1:0]         pitch,
  input  logic [ANGLE_WIDTH-1:0]         yaw,
  output logic                           busy,
  output logic signed [COEF_WIDTH+1:0]   mat [9]
);

  localparam int F  = COEF_WIDTH - 1;
  localparam int MW = COEF_WIDTH + 2;
  localparam logic [ANGLE_WIDTH-1:0] QUARTER = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
  localparam logic signed [2*MW-1:0] RHALF = (2*MW)'(1) << (F - 1);

  typedef enum logic [1:0] {C_IDLE, C_TRIG, C_MAT} state_t;

  state_t     state_r;
  logic [2:0] k_r;
  logic [3:0] op_r;
  logic       launched_r;

  logic signed [COEF_WIDTH-1:0] ca_r, sa_r, cp_r, sp_r, cy_r, sy_r;
  logic signed [MW-1:0] tmp_r;
  logic signed [MW-1:0] m_r [9];

  logic                   sin_start;
  logic [ANGLE_WIDTH-1:0] sin_angle;
  logic                   sin_done;
  logic signed [COEF_WIDTH-1:0] sin_value;

  mat_op_t op;
  logic signed [MW-1:0]     opa, opb;
  logic signed [2*MW-1:0]   prod;
  logic signed [2*MW-1:0]   prod_rnd;
  logic signed [MW-1:0]     fm;
  logic signed [MW-1:0]     acc_old;

  // Angle for the current trig value; even steps are cosines
  always_comb begin
    unique case (k_r[2:1])
      2'd0:    sin_angle = roll;
      2'd1:    sin_angle = pitch;
      default: sin_angle = yaw;
    endcase
    if (!k_r[0]) sin_angle = sin_angle + QUARTER;
    sin_start = (state_r == C_TRIG) && !launched_r;
  end

  erx_sin #(
    .ANGLE_WIDTH(ANGLE_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_sin (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sin_start),
    .angle(sin_angle),
    .done (sin_done),
    .value(sin_value)
  );

  function automatic logic signed [MW-1:0] pick(
    input src_t s,
    input logic signed [COEF_WIDTH-1:0] ca, sa, cp, sp, cy, sy,
    input logic signed [MW-1:0] tmp
  );
    logic signed [MW-1:0] v;
    v = tmp;
    unique case (s)
      SRC_CA:  v = MW'(ca);
      SRC_SA:  v = MW'(sa);
      SRC_CP:  v = MW'(cp);
      SRC_SP:  v = MW'(sp);
      SRC_CY:  v = MW'(cy);
      SRC_SY:  v = MW'(sy);
      default: v = tmp;
    endcase
    return v;
  endfunction

  // One rounded coefficient product per program step
  always_comb begin
    op       = mat_op(op_r);
    opa      = pick(op.src_a, ca_r, sa_r, cp_r, sp_r, cy_r, sy_r, tmp_r);
    opb      = pick(op.src_b, ca_r, sa_r, cp_r, sp_r, cy_r, sy_r, tmp_r);
    prod     = opa * opb;
    prod_rnd = (prod + RHALF) >>> F;
    fm       = prod_rnd[MW-1:0];
    acc_old  = m_r[op.dst];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= C_IDLE;
      k_r        <= 3'd0;
      op_r       <= 4'd0;
      launched_r <= 1'b0;
    end else begin
      unique case (state_r)
        C_IDLE: begin
          if (start) begin
            k_r        <= 3'd0;
            launched_r <= 1'b0;
            state_r    <= C_TRIG;
          end
        end
        C_TRIG: begin
          if (!launched_r) begin
            launched_r <= 1'b1;
          end else if (sin_done) begin
            unique case (k_r)
              3'd0:    ca_r <= sin_value;
              3'd1:    sa_r <= sin_value;
              3'd2:    cp_r <= sin_value;
              3'd3:    sp_r <= sin_value;
              3'd4:    cy_r <= sin_value;
              default: sy_r <= sin_value;
            endcase
            launched_r <= 1'b0;
            if (k_r == 3'd5) begin
              op_r    <= 4'd0;
              state_r <= C_MAT;
            end else begin
              k_r <= k_r + 3'd1;
            end
          end
        end
        C_MAT: begin
          if (op.dst == DST_TMP) begin
            tmp_r <= fm;
          end else begin
            unique case (op.mode)
              ACC_ADD: m_r[op.dst] <= acc_old + fm;
              ACC_SUB: m_r[op.dst] <= acc_old - fm;
              default: m_r[op.dst] <= fm;
            endcase
          end
          if (op_r == 4'(NUM_OPS - 1)) begin
            m_r[DST_M20] <= -MW'(sp_r);
            state_r      <= C_IDLE;
          end
          op_r <= op_r + 4'd1;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign busy = (state_r != C_IDLE);
  assign mat  = m_r;

endmodule

`default_nettype wire

FILE: hdl/erx_lane.sv
// One matrix row against the point: products, rounding, shift and saturation.
// Depends on erx_pkg for the lane control struct.
`default_nettype none

module erx_lane
  import erx_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                           clk,
  input  lane_ctl_t                      ctl,
  input  logic signed [COEF_WIDTH+1:0]   c0,
  input  logic signed [COEF_WIDTH+1:0]   c1,
  input  logic signed [COEF_WIDTH+1:0]   c2,
  input  logic signed [COORD_WIDTH-1:0]  p0,
  input  logic signed [COORD_WIDTH-1:0]  p1,
  input  logic signed [COORD_WIDTH-1:0]  p2,
  input  logic signed [COORD_WIDTH-1:0]  self_pt,
  input  logic signed [COORD_WIDTH-1:0]  shift,
  output logic signed [COORD_WIDTH-1:0]  result,
  output logic                           clip
);

  localparam int F  = COEF_WIDTH - 1;
  localparam int MW = COEF_WIDTH + 2;
  localparam int PW = MW + COORD_WIDTH;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (F - 1);
  localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] LO = SW'(-(64'sd1 <<< (COORD_WIDTH - 1)));

  logic signed [PW-1:0]          pr0_r, pr1_r, pr2_r;
  logic                          byp_r;
  logic signed [COORD_WIDTH-1:0] self_r;
  logic signed [COORD_WIDTH-1:0] result_r;
  logic                          clip_r;

  logic signed [SW-1:0] sum, rnd, tot;

  // Stage A: the three products
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      pr0_r  <= c0 * p0;
      pr1_r  <= c1 * p1;
      pr2_r  <= c2 * p2;
      byp_r  <= ctl.bypass;
      self_r <= self_pt;
    end
  end

  // Stage B: exact sum, round, translate, clamp
  always_comb begin
    sum = SW'(pr0_r) + SW'(pr1_r) + SW'(pr2_r);
    rnd = byp_r ? SW'(self_r) : ((sum + HALF) >>> F);
    tot = rnd + SW'(shift);
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (tot > HI) begin
        result_r <= HI[COORD_WIDTH-1:0];
        clip_r   <= 1'b1;
      end else if (tot < LO) begin
        result_r <= LO[COORD_WIDTH-1:0];
        clip_r   <= 1'b1;
      end else begin
        result_r <= tot[COORD_WIDTH-1:0];
        clip_r   <= 1'b0;
      end
    end
  end

  assign result = result_r;
  assign clip   = clip_r;

endmodule

`default_nettype wire

FILE: hdl/euler_rigid_transform_3d.sv
// Top level: config registers, matrix builder, three row lanes, output merge.
// Depends on erx_pkg, erx_point_if, erx_moved_if, erx_coef, erx_lane.
//
//  channel   dir  handshake          word
//  in_chan   in   valid/ready        point_x, point_y, point_z
//  out_chan  out  valid/ready        moved_x, moved_y, moved_z, clipped
//  cfg_*     in   cfg_we, no wait    cfg_index, cfg_wdata
//
// One point per cycle while out_chan is not stalled and no matrix rebuild is pending.
// Three stages: input register, lane products, round/shift/clamp register.
// A write to an angle register rebuilds the matrix: a start, 6 sine runs
// and 16 program steps, with in_chan.ready low throughout.
// Reset is synchronous; config registers and stage valids clear to zero (pure translation).
// The pipeline advances as a whole whenever the output register is free.
`default_nettype none

module euler_rigid_transform_3d
  import erx_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int ANGLE_WIDTH = 16,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  erx_point_if.sink             in_chan,
  erx_moved_if.source           out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [((COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH)-1:0] cfg_wdata
);

  logic signed [COORD_WIDTH-1:0] shift_x_r, shift_y_r, shift_z_r;
  logic [ANGLE_WIDTH-1:0]        roll_r, pitch_r, yaw_r;
  logic                          dirty_r;
  logic                          angle_wr;

  logic signed [COORD_WIDTH-1:0] px_r, py_r, pz_r;
  logic                          byp0_r;
  logic                          v0_r, v1_r, out_valid_r;

  logic signed [COEF_WIDTH+1:0]  mat [9];
  logic                          coef_busy;
  logic                          adv;
  logic                          in_take;
  lane_ctl_t                     ctl;

  logic signed [COORD_WIDTH-1:0] rx, ry, rz;
  logic                          clip_x, clip_y, clip_z;

  // Flow control: every stage moves when the output register frees
  assign adv     = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv && !dirty_r && !coef_busy;
  assign in_take = in_chan.valid && in_chan.ready;

  // Any angle write calls for a matrix rebuild
  assign angle_wr = cfg_we &&
                    ((cfg_index == REG_ROLL) || (cfg_index == REG_PITCH) ||
                     (cfg_index == REG_YAW));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_x_r <= '0;
      shift_y_r <= '0;
      shift_z_r <= '0;
      roll_r    <= '0;
      pitch_r   <= '0;
      yaw_r     <= '0;
      dirty_r   <= 1'b0;
    end else begin
      if (angle_wr) dirty_r <= 1'b1;
      else if (dirty_r && !coef_busy) dirty_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SHIFT_X: shift_x_r <= cfg_wdata[COORD_WIDTH-1:0];
          REG_SHIFT_Y: shift_y_r <= cfg_wdata[COORD_WIDTH-1:0];
          REG_SHIFT_Z: shift_z_r <= cfg_wdata[COORD_WIDTH-1:0];
          REG_ROLL:    roll_r    <= cfg_wdata[ANGLE_WIDTH-1:0];
          REG_PITCH:   pitch_r   <= cfg_wdata[ANGLE_WIDTH-1:0];
          REG_YAW:     yaw_r     <= cfg_wdata[ANGLE_WIDTH-1:0];
          default: ;
        endcase
      end
    end
  end

  erx_coef #(
    .ANGLE_WIDTH(ANGLE_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_coef (
    .clk  (clk),
    .rst_n(rst_n),
    .start(dirty_r && !coef_busy),
    .roll (roll_r),
    .pitch(pitch_r),
    .yaw  (yaw_r),
    .busy (coef_busy),
    .mat  (mat)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (adv) begin
      px_r   <= in_chan.point_x;
      py_r   <= in_chan.point_y;
      pz_r   <= in_chan.point_z;
      byp0_r <= (roll_r == '0) && (pitch_r == '0) && (yaw_r == '0);
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v0_r        <= in_take;
      v1_r        <= v0_r;
      out_valid_r <= v1_r;
    end
  end

  assign ctl = '{en: adv, bypass: byp0_r};

  erx_lane #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_lane_x (
    .clk(clk), .ctl(ctl),
    .c0(mat[DST_M00]), .c1(mat[DST_M01]), .c2(mat[DST_M02]),
    .p0(px_r), .p1(py_r), .p2(pz_r), .self_pt(px_r), .shift(shift_x_r),
    .result(rx), .clip(clip_x)
  );

  erx_lane #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_lane_y (
    .clk(clk), .ctl(ctl),
    .c0(mat[DST_M10]), .c1(mat[DST_M11]), .c2(mat[DST_M12]),
    .p0(px_r), .p1(py_r), .p2(pz_r), .self_pt(py_r), .shift(shift_y_r),
    .result(ry), .clip(clip_y)
  );

  erx_lane #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_lane_z (
    .clk(clk), .ctl(ctl),
    .c0(mat[DST_M20]), .c1(mat[DST_M21]), .c2(mat[DST_M22]),
    .p0(px_r), .p1(py_r), .p2(pz_r), .self_pt(pz_r), .shift(shift_z_r),
    .result(rz), .clip(clip_z)
  );

  // Merge lanes into the result word
  assign out_chan.valid   = out_valid_r;
  assign out_chan.moved_x = rx;
  assign out_chan.moved_y = ry;
  assign out_chan.moved_z = rz;
  assign out_chan.clipped = clip_x | clip_y | clip_z;

`ifndef SYNTH
  // No point enters while the matrix is being rebuilt
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> !coef_busy && !dirty_r)
    else $error("point accepted during matrix rebuild");

  // A stalled middle stage keeps its word
  a_hold_v1: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !adv |=> v1_r)
    else $error("pipeline word lost under stall");

  // Reset empties the output
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");
`endif

endmodule

`default_nettype wire

FILE: sim/euler_rigid_transform_3d_tb.sv
// Self-checking testbench for euler_rigid_transform_3d: directed table, then random frames.
// Depends on erx_pkg, erx_point_if, erx_moved_if and the block itself.
`timescale 1ns / 1ps

module euler_rigid_transform_3d_tb;
  import erx_pkg::*;

  localparam int CW = 24;
  localparam int AW = 16;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD = 150;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_POINTS = 1930;
  localparam int FRAME_POINTS = 160;
  // Indexes past the last register; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [CW-1:0] C_MAX = 24'h7fffff;
  localparam logic [CW-1:0] C_MIN = 24'h800000;
  localparam logic [CW-1:0] C_NEG1 = 24'hffffff;
  localparam logic [AW-1:0] QUARTER = 16'h4000;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic          clip;
  } moved_t;

  typedef struct {
    logic [CW-1:0] sx, sy, sz;
    logic [AW-1:0] roll, pitch, yaw;
    logic [CW-1:0] px, py, pz;
    bit            typed;
    logic [CW-1:0] ex, ey, ez;
    logic          eclip;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_wdata = '0;

  erx_point_if #(.W(CW)) in_chan ();
  erx_moved_if #(.W(CW)) out_chan ();

  euler_rigid_transform_3d #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW), .COEF_WIDTH(16)) dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Shadow copy of the register file
  logic [CW-1:0] shift_x = '0, shift_y = '0, shift_z = '0;
  logic [AW-1:0] roll_ang = '0, pitch_ang = '0, yaw_ang = '0;

  moved_t moved_q[$];
  int errors = 0;
  int words_sent = 0, words_seen = 0, clip_seen = 0, frames = 0;
  int quiet_cycles = 0;
  bit gappy = 1'b0;
  bit hold_request = 1'b0;

  initial begin
    in_chan.valid = 1'b0;
    in_chan.point_x = '0;
    in_chan.point_y = '0;
    in_chan.point_z = '0;
    out_chan.ready = 1'b0;
  end

  // Q1.15 sine of a binary angle, odd polynomial over a quarter turn
  function automatic longint sin_q15(logic [AW-1:0] a);
    longint unsigned x, x2, p, s;
    logic [1:0] q;
    q = a[AW-1:AW-2];
    x = longint'(a[AW-3:0]) << (30 - (AW - 2));
    if (q[0]) x = (64'd1 << 30) - x;
    x2 = (x * x) >> 30;
    p = 64'(SIN_C9);
    p = 64'(SIN_C7) - ((x2 * p) >> 30);
    p = 64'(SIN_C5) - ((x2 * p) >> 30);
    p = 64'(SIN_C3) - ((x2 * p) >> 30);
    p = 64'(SIN_C1) - ((x2 * p) >> 30);
    s = (x * p) >> 30;
    s = (s + (64'd1 << 14)) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return q[1] ? -longint'(s) : longint'(s);
  endfunction

  function automatic longint cos_q15(logic [AW-1:0] a);
    return sin_q15(a + QUARTER);
  endfunction

  // round half up by 15 fraction bits
  function automatic longint rnd15(longint v);
    return (v + 64'sd16384) >>> 15;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rnd15(a * b);
  endfunction

  function automatic logic [CW-1:0] clamp(longint v, inout logic clip);
    if (v > 64'sd8388607) begin v = 64'sd8388607; clip = 1'b1; end
    if (v < -64'sd8388608) begin v = -64'sd8388608; clip = 1'b1; end
    return v[CW-1:0];
  endfunction

  // Rotate then translate one point with the shadow registers
  function automatic moved_t transform(logic [CW-1:0] px, logic [CW-1:0] py,
                                       logic [CW-1:0] pz);
    longint p[3], t[3], r[3], m[3][3];
    longint ca, sa, cp, sp, cy, sy;
    moved_t res;
    logic clip;
    p[0] = longint'($signed(px));
    p[1] = longint'($signed(py));
    p[2] = longint'($signed(pz));
    t[0] = longint'($signed(shift_x));
    t[1] = longint'($signed(shift_y));
    t[2] = longint'($signed(shift_z));
    if (roll_ang == 0 && pitch_ang == 0 && yaw_ang == 0) begin
      for (int i = 0; i < 3; i++) r[i] = p[i];
    end else begin
      ca = cos_q15(roll_ang);  sa = sin_q15(roll_ang);
      cp = cos_q15(pitch_ang); sp = sin_q15(pitch_ang);
      cy = cos_q15(yaw_ang);   sy = sin_q15(yaw_ang);
      m[0][0] = qmul(cy, cp);
      m[0][1] = qmul(qmul(cy, sa), sp) - qmul(ca, sy);
      m[0][2] = qmul(sa, sy) + qmul(qmul(ca, cy), sp);
      m[1][0] = qmul(cp, sy);
      m[1][1] = qmul(ca, cy) + qmul(qmul(sa, sy), sp);
      m[1][2] = qmul(qmul(ca, sy), sp) - qmul(cy, sa);
      m[2][0] = -sp;
      m[2][1] = qmul(cp, sa);
      m[2][2] = qmul(ca, cp);
      for (int i = 0; i < 3; i++)
        r[i] = rnd15(m[i][0] * p[0] + m[i][1] * p[1] + m[i][2] * p[2]);
    end
    clip = 1'b0;
    res.x = clamp(t[0] + r[0], clip);
    res.y = clamp(t[1] + r[1], clip);
    res.z = clamp(t[2] + r[2], clip);
    res.clip = clip;
    return res;
  endfunction

  function automatic int draw_gap();
    return gappy ? $urandom_range(0, 7) : 0;
  endfunction

  // Drive one point word; the expectation is queued at acceptance
  task automatic send_point(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz,
                            bit typed, moved_t typed_res);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
    @(negedge clk);
    in_chan.valid <= 1'b1;
    in_chan.point_x <= px;
    in_chan.point_y <= py;
    in_chan.point_z <= pz;
    do @(posedge clk); while (!in_chan.ready);
    moved_q.push_back(typed ? typed_res : transform(px, py, pz));
    words_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  // Wait for the pipe to drain, then load a new frame
  task automatic set_frame(logic [CW-1:0] sx, logic [CW-1:0] sy, logic [CW-1:0] sz,
                           logic [AW-1:0] ro, logic [AW-1:0] pi, logic [AW-1:0] ya);
    @(negedge clk);
    in_chan.valid <= 1'b0;
    wait (moved_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_SPARE_LO, CW'($urandom));
    write_reg(REG_SHIFT_X, sx);
    write_reg(REG_SHIFT_Y, sy);
    write_reg(REG_SHIFT_Z, sz);
    // upper bits of angle writes are junk and must be dropped
    write_reg(REG_ROLL, {8'($urandom), ro});
    write_reg(REG_PITCH, {8'($urandom), pi});
    write_reg(REG_YAW, {8'($urandom), ya});
    write_reg(REG_SPARE_HI, CW'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
    shift_x = sx; shift_y = sy; shift_z = sz;
    roll_ang = ro; pitch_ang = pi; yaw_ang = ya;
    frames++;
  endtask

  function automatic logic [AW-1:0] pick_angle();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return QUARTER;
      2: return 16'h8000;
      3: return 16'h7fff;
      4: return 16'hffff;
      5: return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CW-1:0] pick_coord(int mode);
    case (mode)
      0: case ($urandom_range(0, 3))
           0: return C_MAX;
           1: return C_MIN;
           2: return '0;
           default: return C_NEG1;
         endcase
      1: return CW'($urandom_range(0, 2047) - 1024);
      default: return CW'($urandom);
    endcase
  endfunction

  // Result sink: random stalls, plus one long hold-off on request
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        n = LONG_HOLD;
      end else begin
        n = draw_gap();
      end
      repeat (n) begin
        @(negedge clk);
        out_chan.ready <= 1'b0;
      end
      @(negedge clk);
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    moved_t e;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      words_seen++;
      if (out_chan.clipped) clip_seen++;
      if (moved_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = moved_q.pop_front();
        if (out_chan.moved_x !== e.x) begin
          $error("moved_x: expected %h, got %h", e.x, out_chan.moved_x); errors++;
        end
        if (out_chan.moved_y !== e.y) begin
          $error("moved_y: expected %h, got %h", e.y, out_chan.moved_y); errors++;
        end
        if (out_chan.moved_z !== e.z) begin
          $error("moved_z: expected %h, got %h", e.z, out_chan.moved_z); errors++;
        end
        if (out_chan.clipped !== e.clip) begin
          $error("clipped: expected %b, got %b", e.clip, out_chan.clipped); errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake or register write
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL euler_rigid_transform_3d");
      $finish;
    end
  end

  // Directed table: translation and clipping rows are typed in, rotations use the predictor
  row_t plan[] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, C_MAX, C_MIN, 1, 1, C_MAX, C_MIN, 1, 0},
    '{0, 0, 0, 0, 0, 0, C_NEG1, C_MAX, C_MIN, 1, C_NEG1, C_MAX, C_MIN, 0},
    '{C_MAX, C_MIN, 0, 0, 0, 0, 1, C_NEG1, 5, 1, C_MAX, C_MIN, 5, 1},
    '{C_MAX, C_MIN, 0, 0, 0, 0, C_NEG1, 1, 0, 1, 24'h7ffffe, 24'h800001, 0, 0},
    '{C_MAX, C_MIN, 0, 0, 0, 0, C_MAX, C_MAX, C_MIN, 1, C_MAX, C_NEG1, C_MIN, 1},
    '{0, 0, C_MIN, 0, 0, 0, 0, 0, C_NEG1, 1, 0, 0, C_MIN, 1},
    '{0, 0, 0, QUARTER, 0, 0, 24'h000100, 24'h000200, 24'h000300, 0, 0, 0, 0, 0},
    '{0, 0, 0, QUARTER, 0, 0, C_MAX, C_MIN, C_MAX, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 16'h7fff, 0, 24'h001000, C_NEG1, 24'h012345, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 16'h7fff, 16'h8000, C_MIN, C_MIN, C_MIN, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 16'h7fff, 16'h8000, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0, 0},
    '{0, 0, 0, 16'hffff, 16'h0001, 16'h8000, 24'h0abcde, 24'hf54321, 1, 0, 0, 0, 0, 0},
    '{10, C_NEG1, 7, 16'h2000, 16'h2000, 16'h2000, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0, 0},
    '{10, C_NEG1, 7, 16'h2000, 16'h2000, 16'h2000, C_MIN, 0, C_MAX, 0, 0, 0, 0, 0},
    '{C_MAX, C_MAX, C_MAX, QUARTER, QUARTER, QUARTER, C_MAX, 1, C_MIN, 0, 0, 0, 0, 0},
    '{C_MIN, C_MIN, C_MIN, 16'h8000, 16'h8000, 16'h8000, C_MIN, C_MAX, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 16'hc000, 16'h4000, 16'hc000, 24'h123456, 24'h654321, 24'h0f0f0f, 0, 0, 0,
      0, 0}
  };

  initial begin
    moved_t typed_res;
    int mode;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed rows, reloading the frame whenever it changes
    foreach (plan[i]) begin
      if (plan[i].sx !== shift_x || plan[i].sy !== shift_y || plan[i].sz !== shift_z ||
          plan[i].roll !== roll_ang || plan[i].pitch !== pitch_ang ||
          plan[i].yaw !== yaw_ang)
        set_frame(plan[i].sx, plan[i].sy, plan[i].sz,
                  plan[i].roll, plan[i].pitch, plan[i].yaw);
      typed_res = '{plan[i].ex, plan[i].ey, plan[i].ez, plan[i].eclip};
      send_point(plan[i].px, plan[i].py, plan[i].pz, plan[i].typed, typed_res);
    end

    // random frames of random points
    for (int k = 0; k < RANDOM_POINTS; k++) begin
      if (k % FRAME_POINTS == 0) begin
        mode = $urandom_range(0, 3);
        if (mode == 0)
          set_frame(pick_coord(2), pick_coord(1), pick_coord(0), 0, 0, 0);
        else
          set_frame(pick_coord(mode == 1 ? 0 : 2), pick_coord(2), pick_coord(mode == 1 ? 0 : 1),
                    pick_angle(), pick_angle(), pick_angle());
        gappy = $urandom_range(0, 2) != 0;
        if (k == FRAME_POINTS) hold_request = 1'b1;
      end
      mode = $urandom_range(0, 9);
      send_point(pick_coord(mode), pick_coord(mode), pick_coord(mode), 0, typed_res);
    end

    @(negedge clk);
    in_chan.valid <= 1'b0;
    wait (moved_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d points over %0d register frames, got %0d results (%0d clipped).",
             words_sent, frames, words_seen, clip_seen);
    $display("Frames covered pure translation, quarter/half-turn and random angles.");
    if (errors == 0)
      $display("PASS euler_rigid_transform_3d");
    else
      $display("FAIL euler_rigid_transform_3d");
    $finish;
  end

endmodule
